// ----- rtl/core/plia_pkg.sv -----
`timescale 1ns / 1ps
package plia_pkg;

  localparam int WORD_BITS_DEF     = 128;
  localparam int MAX_LANE_BITS_DEF = 16;
  localparam int CFG_W             = 5;
  localparam logic [CFG_W-1:0] LANE_WIDTH_RST = 5'd8;

  // register index, decoded from paddr[2]
  localparam logic REG_LANE_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_UDIV = 3'd3,
    CMD_UREM = 3'd4,
    CMD_POP  = 3'd5,
    CMD_CTZ  = 3'd6,
    CMD_CLZ  = 3'd7
  } cmd_t;

endpackage

// ----- rtl/core/plia_lane.sv -----
`timescale 1ns / 1ps
module plia_lane #(
  parameter int LB = plia_pkg::MAX_LANE_BITS_DEF,
  parameter int WW = $clog2(LB + 1)
) (
  input  logic             clk,
  input  logic             en,
  input  plia_pkg::cmd_t   cmd,
  input  logic [LB-1:0]    x,
  input  logic [LB-1:0]    y,
  input  logic [WW-1:0]    w,
  output logic [LB-1:0]    res
);

  plia_pkg::cmd_t c0;
  logic [LB-1:0]  x0;
  logic [LB-1:0]  y0;

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= cmd;
      x0 <= x;
      y0 <= y;
    end
  end

  logic [LB-1:0]   mask;
  logic [LB-1:0]   simple;
  logic [2*LB-1:0] prod;
  logic [WW-1:0]   pop;
  logic [WW-1:0]   tz;
  logic [WW-1:0]   lz;
  logic            seen;

  always_comb begin
    for (int k = 0; k < LB; k++) begin
      mask[k] = (WW'(k) < w);
    end
    prod = {{LB{1'b0}}, x0} * {{LB{1'b0}}, y0};
    pop = '0;
    for (int k = 0; k < LB; k++) begin
      pop = pop + WW'(x0[k]);
    end
    tz   = WW'(LB);
    seen = 1'b0;
    for (int k = 0; k < LB; k++) begin
      if (!seen && x0[k]) begin
        tz   = WW'(k);
        seen = 1'b1;
      end
    end
    if (x0 == '0) begin
      tz = w;
    end
    lz   = WW'(LB);
    seen = 1'b0;
    for (int k = LB - 1; k >= 0; k--) begin
      if (!seen && x0[k]) begin
        lz   = WW'(LB - 1 - k);
        seen = 1'b1;
      end
    end
    // zero-extended lane: drop the leading pad bits
    lz = lz - (WW'(LB) - w);
    unique case (c0)
      plia_pkg::CMD_ADD: simple = (x0 + y0) & mask;
      plia_pkg::CMD_SUB: simple = (x0 - y0) & mask;
      plia_pkg::CMD_MUL: simple = prod[LB-1:0] & mask;
      plia_pkg::CMD_POP: simple = LB'(pop);
      plia_pkg::CMD_CTZ: simple = LB'(tz);
      plia_pkg::CMD_CLZ: simple = LB'(lz);
      default:           simple = '0;
    endcase
  end

  // restoring divider, one quotient bit per stage
  logic [LB-1:0]  rm [LB];
  logic [LB-1:0]  qt [LB];
  logic [LB-1:0]  dv [LB];
  plia_pkg::cmd_t cs [LB];
  logic [LB-1:0]  sm [LB];

  for (genvar s = 0; s < LB; s++) begin : g_div
    logic [LB-1:0]  r_in;
    logic [LB-1:0]  q_in;
    logic [LB-1:0]  d_in;
    plia_pkg::cmd_t c_in;
    logic [LB-1:0]  s_in;
    logic [LB:0]    t;
    logic           ge;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = x0;
      assign d_in = y0;
      assign c_in = c0;
      assign s_in = simple;
    end else begin : g_next
      assign r_in = rm[s-1];
      assign q_in = qt[s-1];
      assign d_in = dv[s-1];
      assign c_in = cs[s-1];
      assign s_in = sm[s-1];
    end

    assign t  = {r_in, q_in[LB-1]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rm[s] <= ge ? LB'(t - {1'b0, d_in}) : t[LB-1:0];
        qt[s] <= {q_in[LB-2:0], ge};
        dv[s] <= d_in;
        cs[s] <= c_in;
        sm[s] <= s_in;
      end
    end
  end

  always_comb begin
    unique case (cs[LB-1])
      plia_pkg::CMD_UDIV: res = qt[LB-1] & mask;
      plia_pkg::CMD_UREM: res = rm[LB-1];
      default:            res = sm[LB-1];
    endcase
  end

endmodule

// ----- rtl/core/plia_merge.sv -----
`timescale 1ns / 1ps
module plia_merge #(
  parameter int WORD_BITS = plia_pkg::WORD_BITS_DEF,
  parameter int LB        = plia_pkg::MAX_LANE_BITS_DEF,
  parameter int WW        = $clog2(LB + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [LB-1:0] res [WORD_BITS],
  input  logic [WW-1:0] w,
  output logic [127:0]  word
);

  logic [127:0] packed_w;

  // lane i, bit k lands at i*w + k; only whole lanes are placed
  always_comb begin
    packed_w = '0;
    for (int ww = 1; ww <= LB; ww++) begin
      if (w == WW'(ww)) begin
        for (int i = 0; (i + 1) * ww <= WORD_BITS; i++) begin
          for (int k = 0; k < ww; k++) begin
            packed_w[i * ww + k] = res[i][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= packed_w;
    end
  end

endmodule

// ----- rtl/core/packed_lane_integer_alu_core.sv -----
`timescale 1ns / 1ps
// Packed-lane integer ALU.
// Input stream: one word holds cmd and two 128-bit operands; each operand is
// cut into lanes of lane_width bits from bit 0 and every lane gets the same
// operation (add, sub, low multiply, udiv, urem, popcount, ctz, clz).
// Output stream: one 128-bit word of packed lane results per input word;
// bits above the last whole lane are zero.
// lane_width is written over the APB port at address 0; the user must do so
// only while the block is idle; the block does not enforce it. Values above
// MAX_LANE_BITS act as MAX_LANE_BITS, zero gives zero. Stages: operand
// capture, one divider stage per quotient bit, and the packing register.
// Throughput is one word per cycle when not stalled; every lane has its own
// fully pipelined divider. When the receiver stalls with a result held, the
// whole pipeline freezes and s_tready drops; it rises again as soon as the
// held word is taken. Reset clears the valid pipeline, sets lane_width to 8.
module packed_lane_integer_alu_core #(
  parameter int WORD_BITS     = plia_pkg::WORD_BITS_DEF,
  parameter int MAX_LANE_BITS = plia_pkg::MAX_LANE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd[2:0], a_low[66:3], a_high[130:67], b_low[194:131], b_high[258:195]
  input  logic [263:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_low[63:0], r_high[127:64]
  output logic [127:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int LB  = MAX_LANE_BITS;
  localparam int WW  = $clog2(LB + 1);
  localparam int LAT = LB + 1;

  logic [plia_pkg::CFG_W-1:0] lane_width;

  assign pready = 1'b1;
  assign prdata = {{(32 - plia_pkg::CFG_W){1'b0}}, lane_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_width <= plia_pkg::LANE_WIDTH_RST;
    end else if (psel && penable && pwrite && paddr[2] == plia_pkg::REG_LANE_WIDTH) begin
      lane_width <= pwdata[plia_pkg::CFG_W-1:0];
    end
  end

  logic [WW-1:0] w;
  always_comb begin
    if ({1'b0, lane_width} > 6'(LB)) begin
      w = WW'(LB);
    end else begin
      w = WW'(lane_width);
    end
  end

  logic advance;
  logic [LAT-1:0] vld;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      vld      <= {vld[LAT-2:0], s_tvalid};
      m_tvalid <= vld[LAT-1];
    end
  end

  logic [127:0] a_word;
  logic [127:0] b_word;
  plia_pkg::cmd_t cmd;

  assign cmd    = plia_pkg::cmd_t'(s_tdata[2:0]);
  assign a_word = s_tdata[130:3];
  assign b_word = s_tdata[258:131];

  logic [LB-1:0] xl [WORD_BITS];
  logic [LB-1:0] yl [WORD_BITS];
  logic [LB-1:0] rl [WORD_BITS];

  // lane i, bit k sits at i*w + k for the configured width
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      xl[i] = '0;
      yl[i] = '0;
      for (int ww = 1; ww <= LB; ww++) begin
        if (w == WW'(ww) && (i + 1) * ww <= WORD_BITS) begin
          for (int k = 0; k < ww; k++) begin
            xl[i][k] = a_word[i * ww + k];
            yl[i][k] = b_word[i * ww + k];
          end
        end
      end
    end
  end

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_lane
    plia_lane #(.LB(LB), .WW(WW)) u_lane (
      .clk (clk),
      .en  (advance),
      .cmd (cmd),
      .x   (xl[i]),
      .y   (yl[i]),
      .w   (w),
      .res (rl[i])
    );
  end

  plia_merge #(.WORD_BITS(WORD_BITS), .LB(LB), .WW(WW)) u_merge (
    .clk  (clk),
    .en   (advance),
    .res  (rl),
    .w    (w),
    .word (m_tdata)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int LATENCY = plia_pkg::MAX_LANE_BITS_DEF + 2;

  class lane_result_board;
    logic [127:0] pending[$];
    int errors;
    logic [4:0] lane_width;

    function new();
      errors = 0;
      lane_width = plia_pkg::LANE_WIDTH_RST;
    endfunction

    // per-lane operation at width w; a and b are already masked to w bits
    function logic [31:0] lane_calc(plia_pkg::cmd_t op, logic [31:0] a, logic [31:0] b,
                                    int w);
      logic [31:0] m;
      logic [63:0] prod;
      int n;
      m = (32'd1 << w) - 1;
      n = 0;
      case (op)
        plia_pkg::CMD_ADD:  return (a + b) & m;
        plia_pkg::CMD_SUB:  return (a - b) & m;
        plia_pkg::CMD_MUL: begin
          prod = a * b;
          return prod[31:0] & m;
        end
        plia_pkg::CMD_UDIV: return (b == 0) ? m : (a / b) & m;
        plia_pkg::CMD_UREM: return (b == 0) ? a : (a % b) & m;
        plia_pkg::CMD_POP: begin
          for (int k = 0; k < w; k++) n += a[k];
          return n;
        end
        plia_pkg::CMD_CTZ: begin
          for (int k = 0; k < w && !a[k]; k++) n++;
          return n;
        end
        default: begin
          for (int k = w; k > 0 && !a[k-1]; k--) n++;
          return n;
        end
      endcase
    endfunction

    function void note_word(plia_pkg::cmd_t op, logic [127:0] a, logic [127:0] b);
      logic [127:0] r;
      logic [31:0] x, y, z;
      int w, lanes;
      r = '0;
      w = lane_width;
      if (w > plia_pkg::MAX_LANE_BITS_DEF) w = plia_pkg::MAX_LANE_BITS_DEF;
      lanes = (w == 0) ? 0 : 128 / w;
      for (int i = 0; i < lanes; i++) begin
        x = 0;
        y = 0;
        for (int k = 0; k < w; k++) begin
          x[k] = a[i*w+k];
          y[k] = b[i*w+k];
        end
        z = lane_calc(op, x, y, w);
        for (int k = 0; k < w; k++) r[i*w+k] = z[k];
      end
      pending = {pending, r};
    endfunction

    function void check_word(logic [127:0] got);
      logic [127:0] exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got[63:0] !== exp_r[63:0]) begin
        $error("r_low: expected %h, got %h", exp_r[63:0], got[63:0]);
        errors++;
      end
      if (got[127:64] !== exp_r[127:64]) begin
        $error("r_high: expected %h, got %h", exp_r[127:64], got[127:64]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [263:0] s_tdata;
  logic [127:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  int send_idle_pct, recv_idle_pct;
  lane_result_board board;

  packed_lane_integer_alu_core DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random backpressure, check at rising edge
  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata);
  end

  task automatic write_lane_width(logic [4:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= {27'd0, v};
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    board.lane_width = v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_word(plia_pkg::cmd_t op, logic [127:0] a, logic [127:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_word(op, a, b);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [127:0] rand_word();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      2: v = v & {$urandom, $urandom, $urandom, $urandom}; // sparse bits
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [4:0] widths[$];
    board = new();
    rst = 1;
    s_tvalid = 0; s_tdata = '0; m_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle_pct = 24; recv_idle_pct = 45;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: every op at reset width, extremes, divide by zero, zero lanes
    for (int c = 0; c < 8; c++) begin
      send_word(plia_pkg::cmd_t'(c), '1, '1);
      send_word(plia_pkg::cmd_t'(c), '1, '0);
      send_word(plia_pkg::cmd_t'(c), '0, {64'h0123456789abcdef, 64'hfedcba9876543210});
    end
    drain();

    widths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd7, 5'd13, 5'd5, 5'd12, 5'd9,
               5'd2, 5'd15, 5'd11, 5'd4, 5'd6, 5'd10, 5'd14, 5'd8, 5'd30};
    for (int p = 0; p < widths.size(); p++) begin
      if (p == 7) begin send_idle_pct = 45; recv_idle_pct = 24; end
      if (p == 14) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_lane_width(widths[p]);
      for (int n = 0; n < 65; n++)
        send_word(plia_pkg::cmd_t'($urandom_range(7)), rand_word(), rand_word());
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
